// File: rtl/nsfs_pkg.sv
// Shared types, codes and constants for the NMEA sentence field splitter.
// No dependencies.
`timescale 1ns / 1ps

package nsfs_pkg;

  localparam int MAX_FIELDS      = 24;
  localparam int MAX_FIELD_CHARS = 20;
  localparam int NUM_TYPES       = 6;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_STAR   = 8'h2a;

  localparam logic [5:0] MASK_RESET   = 6'd3;
  localparam logic [7:0] MAXLEN_RESET = 8'd82;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_TYPE_MASK = 1'b0,
    CFG_MAX_LEN   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic is_dollar;
    logic is_comma;
    logic is_star;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
  } q_item_t;

  localparam logic [47:0] HDR_TAB [NUM_TYPES] = '{
    "$GNRMC", "$GNGGA", "$GNGSA", "$GNGSV", "$GNGLL", "$GNVTG"
  };

  // character p (0..5) of header t
  function automatic logic [7:0] hdr_char(input int t, input logic [2:0] p);
    logic [5:0] sh;
    sh = 6'(8 * (5 - int'(p)));
    return HDR_TAB[t][sh +: 8];
  endfunction

endpackage

// File: rtl/nsfs_front.sv
// Front end: classifies each received byte and writes it to the queue.
// Depends on nsfs_pkg.
`timescale 1ns / 1ps

module nsfs_front (
  input  logic             push,
  input  logic [7:0]       rx_byte,
  input  logic             q_full,
  output logic             full,
  output logic             q_wr,
  output nsfs_pkg::q_item_t q_item
);
  import nsfs_pkg::*;

  assign full                 = q_full;
  assign q_wr                 = push & ~q_full;
  assign q_item.data          = rx_byte;
  assign q_item.cls.is_dollar = (rx_byte == CH_DOLLAR);
  assign q_item.cls.is_comma  = (rx_byte == CH_COMMA);
  assign q_item.cls.is_star   = (rx_byte == CH_STAR);

endmodule

// File: rtl/nsfs_queue.sv
// Short queue of classified items between front and back.
// Depends on nsfs_pkg.
`timescale 1ns / 1ps

module nsfs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  nsfs_pkg::q_item_t wdata,
  input  logic              rd,
  output nsfs_pkg::q_item_t rdata,
  output logic              q_empty,
  output logic              q_full
);
  import nsfs_pkg::*;

  q_item_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign q_empty = (count == '0);
  assign q_full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (rd) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      if (wr && !rd) count <= count + (QUEUE_AW+1)'(1);
      else if (!wr && rd) count <= count - (QUEUE_AW+1)'(1);
    end
  end

endmodule

// File: rtl/nsfs_back.sv
// Back end: sentence parser state machine, configuration registers and
// result register. Depends on nsfs_pkg.
`timescale 1ns / 1ps

module nsfs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  nsfs_pkg::q_item_t q_item,
  output logic              q_rd,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        kind,
  output logic [2:0]        sentence_type,
  output logic [4:0]        field_index,
  output logic [7:0]        field_char,
  output logic              empty_field,
  output logic              last
);
  import nsfs_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HEAD  = 2'd1,
    PH_SKIP  = 2'd2,
    PH_FIELD = 2'd3
  } phase_t;

  phase_t         phase, phase_next;
  logic [2:0]     hpos, hpos_next;
  logic [5:0]     cand, cand_next;
  logic [2:0]     ctype, ctype_next;
  logic [4:0]     cfield, cfield_next;
  logic [4:0]     flen, flen_next;
  logic [7:0]     bcount, bcount_next;
  logic [5:0]     type_mask;
  logic [7:0]     max_len;
  logic           out_valid;

  logic           take;
  logic           res_v;
  kind_t          res_kind;
  logic [7:0]     res_char;
  logic           res_empty;
  logic           res_last;
  logic [2:0]     pos;
  logic [5:0]     keep;
  logic [2:0]     first_t;

  assign cfg_ready = 1'b1;
  assign empty     = ~out_valid;
  assign q_rd      = take;
  assign take      = ~q_empty & (~out_valid | pop);

  always_comb begin
    phase_next  = phase;
    hpos_next   = hpos;
    cand_next   = cand;
    ctype_next  = ctype;
    cfield_next = cfield;
    flen_next   = flen;
    bcount_next = bcount;
    res_v       = 1'b0;
    res_kind    = KIND_CHAR;
    res_char    = '0;
    res_empty   = 1'b0;
    res_last    = 1'b0;
    pos         = (hpos > 3'd5) ? 3'd5 : hpos;
    keep        = '0;
    first_t     = '0;
    for (int t = 0; t < NUM_TYPES; t++) begin
      keep[t] = cand[t] & (hdr_char(t, pos) == q_item.data);
    end
    for (int t = NUM_TYPES - 1; t >= 0; t--) begin
      if (keep[t]) first_t = 3'(t);
    end

    if (take) begin
      if (q_item.cls.is_dollar) begin
        phase_next  = PH_HEAD;
        hpos_next   = 3'd1;
        cand_next   = type_mask;
        ctype_next  = '0;
        cfield_next = '0;
        flen_next   = '0;
        bcount_next = 8'd1;
      end else if (phase != PH_HUNT) begin
        if (bcount != 8'hff) bcount_next = bcount + 8'd1;
        if (bcount > max_len) begin
          phase_next = PH_HUNT;
          if (phase != PH_HEAD) begin
            res_v    = 1'b1;
            res_kind = KIND_ERROR;
            res_last = 1'b1;
          end
        end else begin
          unique case (phase)
            PH_HEAD: begin
              cand_next = keep;
              if (keep == '0) begin
                phase_next = PH_HUNT;
              end else if (pos >= 3'd5) begin
                ctype_next = first_t;
                phase_next = PH_SKIP;
              end else begin
                hpos_next = pos + 3'd1;
              end
            end
            PH_SKIP: begin
              if (q_item.cls.is_comma) begin
                phase_next  = PH_FIELD;
                cfield_next = '0;
                flen_next   = '0;
              end
            end
            PH_FIELD: begin
              res_v = 1'b1;
              if (q_item.cls.is_star) begin
                res_kind   = KIND_END;
                res_empty  = (flen == '0);
                res_last   = 1'b1;
                phase_next = PH_HUNT;
              end else if (q_item.cls.is_comma) begin
                if ({1'b0, cfield} + 6'd1 >= 6'(MAX_FIELDS)) begin
                  res_kind   = KIND_ERROR;
                  res_last   = 1'b1;
                  phase_next = PH_HUNT;
                end else begin
                  res_kind    = KIND_END;
                  res_empty   = (flen == '0);
                  cfield_next = cfield + 5'd1;
                  flen_next   = '0;
                end
              end else if (flen >= 5'(MAX_FIELD_CHARS)) begin
                res_kind   = KIND_ERROR;
                res_last   = 1'b1;
                phase_next = PH_HUNT;
              end else begin
                res_char  = q_item.data;
                flen_next = flen + 5'd1;
              end
            end
            default: begin
              phase_next = PH_HUNT;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      hpos      <= '0;
      cand      <= '0;
      ctype     <= '0;
      cfield    <= '0;
      flen      <= '0;
      bcount    <= '0;
      type_mask <= MASK_RESET;
      max_len   <= MAXLEN_RESET;
      out_valid <= 1'b0;
    end else begin
      phase  <= phase_next;
      hpos   <= hpos_next;
      cand   <= cand_next;
      ctype  <= ctype_next;
      cfield <= cfield_next;
      flen   <= flen_next;
      bcount <= bcount_next;
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TYPE_MASK: type_mask <= cfg_data[5:0];
          CFG_MAX_LEN:   max_len   <= cfg_data;
          default:       type_mask <= type_mask;
        endcase
      end
      if (take) out_valid <= res_v;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_v) begin
      kind          <= res_kind;
      sentence_type <= ctype;
      field_index   <= cfield;
      field_char    <= res_char;
      empty_field   <= res_empty;
      last          <= res_last;
    end
  end

endmodule

// File: rtl/nmea_sentence_field_splitter_unit.sv
// Top level of the NMEA sentence field splitter.
// Depends on nsfs_pkg, nsfs_front, nsfs_queue and nsfs_back.
`timescale 1ns / 1ps

// Takes one received byte per clock while full is low and splits enabled
// $GNxxx sentences into field characters and field ends, each tagged with
// type and field index; an overrun gives an error item with last set.
// Bytes pass a four-entry queue to the parser, which handles one byte per
// cycle unless an unpopped result holds it, and keeps each result in a
// single output register after the queue memory; the block sustains one
// byte per clock while results are popped as fast.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data
// and are always ready; write them only while the block is idle.
module nmea_sentence_field_splitter_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [2:0] sentence_type,
  output logic [4:0] field_index,
  output logic [7:0] field_char,
  output logic       empty_field,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import nsfs_pkg::*;

  q_item_t wr_item;
  q_item_t rd_item;
  logic    q_wr;
  logic    q_rd;
  logic    q_full;
  logic    q_empty;

  nsfs_front u_front (
    .push    (push),
    .rx_byte (rx_byte),
    .q_full  (q_full),
    .full    (full),
    .q_wr    (q_wr),
    .q_item  (wr_item)
  );

  nsfs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (wr_item),
    .rd      (q_rd),
    .rdata   (rd_item),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  nsfs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_item        (rd_item),
    .q_rd          (q_rd),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .sentence_type (sentence_type),
    .field_index   (field_index),
    .field_char    (field_char),
    .empty_field   (empty_field),
    .last          (last)
  );

endmodule
